FILE: rtl/frb_pkg.sv
// Shared types and constants for the flow record batcher.
// Used by frb_ctrl, frb_datapath and flow_record_batcher; no dependencies.
package frb_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LOCAL_NETWORK  = 2'd0;
    localparam logic [1:0] REG_LOCAL_NETMASK  = 2'd1;
    localparam logic [1:0] REG_FLUSH_INTERVAL = 2'd2;

    localparam logic [15:0] FLUSH_INTERVAL_RESET = 16'd41;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 56;

    // Input packet summary, source address in the lowest bits
    typedef struct packed {
        logic [31:0] current_time_ms;
        logic [1:0]  protocol_kind;
        logic [15:0] packet_length;
        logic [31:0] destination_address;
        logic [31:0] source_address;
    } in_item_t;

    // One stored flow record (51 bits)
    typedef struct packed {
        logic        is_incoming;
        logic [31:0] local_host_bits;
        logic [1:0]  record_protocol;
        logic [15:0] record_length;
    } flow_rec_t;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } frb_state_t;

    // Controller to datapath
    typedef struct packed {
        logic store;        // write the classified record into the store
        logic start_flush;  // latch batch size, clear count, update flush time
        logic issue_rd;     // read the next stored record
    } frb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic keep;         // packet has a local end
        logic flush_hit;    // store full or interval passed after this record
        logic all_issued;   // every record of the batch has been read
        logic rd_pending;   // read data waits for the output register
        logic out_free;     // output register can take data this cycle
    } frb_status_t;

endpackage

FILE: rtl/frb_ctrl.sv
// Controller state machine of the flow record batcher.
// Depends on frb_pkg; drives commands into frb_datapath.
module frb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  frb_pkg::frb_status_t status,
    output frb_pkg::frb_cmd_t   cmd
);
    import frb_pkg::*;

    frb_state_t state_reg;
    frb_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd.store       = 1'b0;
        cmd.start_flush = 1'b0;
        cmd.issue_rd    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && status.keep)
                begin
                    cmd.store = 1'b1;
                    if (status.flush_hit)
                    begin
                        cmd.start_flush = 1'b1;
                        state_next      = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // one read in flight at most, refilled as the output drains
                cmd.issue_rd = !status.all_issued &&
                               (!status.rd_pending || status.out_free);
                if (status.all_issued && !status.rd_pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Assertions
    a_no_read_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmd.issue_rd)
        else $error("read issued outside of a drain");
    a_flush_enters_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_flush |=> (state_reg == ST_DRAIN))
        else $error("flush did not start a drain");
    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !cmd.store)
        else $error("record stored during a drain");

endmodule

FILE: rtl/frb_datapath.sv
// Datapath of the flow record batcher: classifier, record store, batch counters,
// flush timer and output register. Depends on frb_pkg; controlled by frb_ctrl.
module frb_datapath #(
    parameter int BATCH_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  frb_pkg::in_item_t   in_item,
    input  logic [31:0]         local_network,
    input  logic [31:0]         local_netmask,
    input  logic [15:0]         flush_interval_ms,
    input  frb_pkg::frb_cmd_t   cmd,
    output frb_pkg::frb_status_t status,
    input  logic                out_ready,
    output logic                out_valid,
    output frb_pkg::flow_rec_t  out_rec,
    output logic                out_last
);
    import frb_pkg::*;

    localparam int CW = $clog2(BATCH_DEPTH + 1);
    localparam int AW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;

    flow_rec_t       store_mem [BATCH_DEPTH];

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   total_reg;
    logic [CW-1:0]   rd_idx_reg;
    logic [31:0]     last_flush_reg;
    logic            rdv_reg;
    logic            rdv_next;
    logic            rd_last_reg;
    flow_rec_t       rd_data_reg;
    logic            out_valid_reg;
    logic            out_last_reg;
    flow_rec_t       out_rec_reg;

    logic            src_local;
    logic            dst_local;
    flow_rec_t       new_rec;
    logic [CW-1:0]   count_plus;
    logic [31:0]     elapsed;
    logic            load_out;
    logic            out_free;

    // Classify the packet; the source test wins when both ends are local
    assign src_local = (in_item.source_address & local_netmask) == local_network;
    assign dst_local = (in_item.destination_address & local_netmask) == local_network;

    always_comb
    begin
        new_rec.is_incoming     = !src_local;
        new_rec.local_host_bits = src_local ? (in_item.source_address & ~local_netmask)
                                            : (in_item.destination_address & ~local_netmask);
        new_rec.record_protocol = in_item.protocol_kind;
        new_rec.record_length   = in_item.packet_length;
    end

    // Flush decision: store full, or elapsed time (mod 2^32) beyond the interval
    assign count_plus = count_reg + 1'b1;
    assign elapsed    = in_item.current_time_ms - last_flush_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign load_out = rdv_reg && out_free;

    always_comb
    begin
        status.keep       = src_local || dst_local;
        status.flush_hit  = (count_plus == CW'(BATCH_DEPTH)) ||
                            (elapsed > {16'd0, flush_interval_ms});
        status.all_issued = rd_idx_reg == total_reg;
        status.rd_pending = rdv_reg;
        status.out_free   = out_free;
    end

    // Record store write port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            store_mem[count_reg[AW-1:0]] <= new_rec;
        end
    end

    // Record store read port, registered
    always_ff @(posedge clk)
    begin
        if (cmd.issue_rd)
        begin
            rd_data_reg <= store_mem[rd_idx_reg[AW-1:0]];
            rd_last_reg <= (rd_idx_reg + 1'b1) == total_reg;
        end
    end

    // Batch count, batch size, read index and flush time
    always_comb
    begin
        count_next = count_reg;
        if (cmd.start_flush)
        begin
            count_next = '0;
        end
        else if (cmd.store)
        begin
            count_next = count_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            total_reg      <= '0;
            rd_idx_reg     <= '0;
            last_flush_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.start_flush)
            begin
                total_reg      <= count_plus;
                rd_idx_reg     <= '0;
                last_flush_reg <= in_item.current_time_ms;
            end
            else if (cmd.issue_rd)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    // Read data valid flag
    always_comb
    begin
        rdv_next = rdv_reg;
        if (cmd.issue_rd)
        begin
            rdv_next = 1'b1;
        end
        else if (load_out)
        begin
            rdv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg <= 1'b0;
        end
        else
        begin
            rdv_reg <= rdv_next;
        end
    end

    // Output register: holds a result while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_rec_reg  <= rd_data_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;
    assign out_last  = out_last_reg;

    // Assertions
    a_count_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(BATCH_DEPTH))
        else $error("record count reached the store depth");
    a_rd_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= total_reg)
        else $error("read index ran past the batch size");
    a_flush_needs_store: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_flush |-> cmd.store)
        else $error("flush without a stored record");
    a_issue_not_all: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_rd |-> (rd_idx_reg < total_reg) && !cmd.store)
        else $error("read issued beyond the batch");

endmodule

FILE: rtl/flow_record_batcher.sv
// Top level of the flow record batcher: configuration registers with APB access,
// stream packing, controller and datapath. Depends on frb_pkg, frb_ctrl, frb_datapath.
//
//  channel   dir  handshake                 contents
//  s_axis    in   s_tvalid / s_tready       packet summary (s_tdata)
//  m_axis    out  m_tvalid / m_tready       flow record (m_tdata, m_tuser, m_tlast)
//  apb       in   psel / penable / pready   local_network, local_netmask, flush_interval_ms
//
// A packet summary is taken when s_tvalid and s_tready are both high; a dropped or
// stored-only packet frees the input the next cycle. A flush holds s_tready low while
// the batch drains through the store's registered read port, one record per cycle when
// m_tready stays high, until the last record has moved from the read port into the
// output register; m_tready stalls stretch the drain. The last record may still wait in
// the output register while the next summary is taken.
// Reset clears count, flush time and valid flags; the store itself is not cleared.
module flow_record_batcher #(
    parameter int BATCH_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // packet summary stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // source_address, destination_address, packet_length, protocol_kind,
    // current_time_ms (low bit up), zero padded
    input  logic [frb_pkg::IN_TDATA_W-1:0]  s_tdata,
    // flow record stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // local_host_bits, record_protocol, record_length (low bit up), zero padded
    output logic [frb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // is_incoming
    output logic                            m_tuser,
    // last_in_batch
    output logic                            m_tlast,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import frb_pkg::*;

    logic [31:0]  local_network_reg;
    logic [31:0]  local_netmask_reg;
    logic [15:0]  flush_interval_reg;
    logic         cfg_write;
    logic [1:0]   reg_idx;

    in_item_t     in_item;
    frb_cmd_t     cmd;
    frb_status_t  status;
    flow_rec_t    out_rec;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_network_reg  <= '0;
            local_netmask_reg  <= '0;
            flush_interval_reg <= FLUSH_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_LOCAL_NETWORK:  local_network_reg  <= pwdata;
                REG_LOCAL_NETMASK:  local_netmask_reg  <= pwdata;
                REG_FLUSH_INTERVAL: flush_interval_reg <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_LOCAL_NETWORK:  prdata = local_network_reg;
            REG_LOCAL_NETMASK:  prdata = local_netmask_reg;
            REG_FLUSH_INTERVAL: prdata = {16'd0, flush_interval_reg};
            default:            prdata = '0;
        endcase
    end

    // Input unpacking
    assign in_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);

    frb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frb_datapath #(
        .BATCH_DEPTH (BATCH_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_item           (in_item),
        .local_network     (local_network_reg),
        .local_netmask     (local_netmask_reg),
        .flush_interval_ms (flush_interval_reg),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_rec           (out_rec),
        .out_last          (m_tlast)
    );

    // Output packing
    assign m_tdata = {6'd0, out_rec.record_length, out_rec.record_protocol,
                      out_rec.local_host_bits};
    assign m_tuser = out_rec.is_incoming;

endmodule
